### hw/rtl/sbhv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbhv_pkg
// Shared types, constants and helpers of the store bank header validator.
// ----------------------------------------------------------------------------
package sbhv_pkg;

  localparam int BANK_BYTES  = 32768;
  localparam int MAX_ENTRIES = 32;
  localparam int ENTRY_BYTES = 48;

  localparam logic [31:0] STORE_MAGIC = 32'h5453_504C;
  localparam logic [31:0] FNV_BASIS   = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME   = 32'd16777619;

  localparam logic [4:0]  HDR_V1_BYTES = 5'd20;
  localparam logic [4:0]  HDR_V2_BYTES = 5'd24;
  localparam logic [15:0] POS_MAX      = 16'hFFFF;
  localparam logic [16:0] POS_OVERRUN  = 17'h10000;

  // Widths of the header-plus-directory size sum.
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int ENT_W  = $clog2(ENTRY_BYTES + 1);
  localparam int NEED_W = CNT_W + ENT_W + 1;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_V1      = 2'd1,
    KIND_V2      = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_MAGIC    = 3'd1,
    ST_BAD_VERSION  = 3'd2,
    ST_BAD_SIZES    = 3'd3,
    ST_BAD_CHECKSUM = 3'd4
  } status_t;

  // Header state captured on the final byte of a bank.
  typedef struct packed {
    logic        magic_good;
    kind_t       kind;
    logic [31:0] count;
    logic [31:0] length;
    logic [31:0] checksum;
    logic [31:0] generation;
    logic [31:0] hash;
    logic [16:0] received;
  } snap_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  header_bytes;
    logic [5:0]  dir_entries;
    logic [15:0] total_bytes;
    logic [31:0] bank_generation;
  } res_t;

  function automatic logic [4:0] hdr_len(input kind_t kind);
    return (kind == KIND_V2) ? HDR_V2_BYTES : HDR_V1_BYTES;
  endfunction

endpackage

### hw/rtl/sbhv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbhv_if
// Valid/ready channels of the validator: bank bytes in, verdicts out.
// ----------------------------------------------------------------------------
interface sbhv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       bank_end;

  modport source (output valid, output data_byte, output bank_end, input ready);
  modport sink   (input valid, input data_byte, input bank_end, output ready);
endinterface

interface sbhv_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [4:0]  header_bytes;
  logic [5:0]  dir_entries;
  logic [15:0] total_bytes;
  logic [31:0] bank_generation;

  modport source (output valid, output status, output header_bytes, output dir_entries,
                  output total_bytes, output bank_generation, input ready);
  modport sink   (input valid, input status, input header_bytes, input dir_entries,
                  input total_bytes, input bank_generation, output ready);
endinterface

### hw/rtl/store_bank_header_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// store_bank_header_validator
// Streams the bytes of a store bank, checks its header and FNV-1a checksum.
// ----------------------------------------------------------------------------
// The block takes one bank byte per cycle while its capture stage can move
// on (a stalled output holds ready low), with the final byte of each bank
// flagged by bank_end; the FNV-1a hash step, one constant multiply per byte,
// completes in the cycle the byte is taken. Each bank gives exactly one
// verdict word: its header state is captured into a snapshot register, then
// graded and registered into the output register. Banks may follow one
// another with no gap, and the block resets its header state itself after every final byte.
module store_bank_header_validator (
  input  logic              clk,
  input  logic              rst_n,
  sbhv_in_if.sink           in_word,
  sbhv_out_if.source        out_word
);

  logic [15:0]       pos_r, pos_nxt;
  logic              ovr_r, ovr_nxt;
  logic [31:0]       gather_r, gather_nxt;
  logic              magic_r, magic_nxt;
  sbhv_pkg::kind_t   kind_r, kind_nxt;
  logic [31:0]       count_r, count_nxt;
  logic [31:0]       length_r, length_nxt;
  logic [31:0]       csum_r, csum_nxt;
  logic [31:0]       gen_r, gen_nxt;
  logic [31:0]       hash_r, hash_nxt;

  sbhv_pkg::snap_t   snap_r, snap_nxt;
  logic              snap_v_r;
  sbhv_pkg::res_t    res_r, verdict;
  logic              out_v_r;

  logic              out_free;
  logic              snap_free;
  logic              in_acc;

  assign out_free      = !out_v_r || out_word.ready;
  assign snap_free     = !snap_v_r || out_free;
  assign in_word.ready = snap_free;
  assign in_acc        = in_word.valid && snap_free;

  always_comb begin
    pos_nxt    = pos_r;
    ovr_nxt    = ovr_r;
    gather_nxt = gather_r;
    magic_nxt  = magic_r;
    kind_nxt   = kind_r;
    count_nxt  = count_r;
    length_nxt = length_r;
    csum_nxt   = csum_r;
    gen_nxt    = gen_r;
    hash_nxt   = hash_r;
    snap_nxt   = snap_r;

    if (in_acc && !ovr_r) begin
      if (pos_r < 16'(sbhv_pkg::HDR_V2_BYTES)) begin
        gather_nxt = {in_word.data_byte, gather_r[31:8]};
        if (pos_r[1:0] == 2'd3) begin
          case (pos_r[4:2])
            3'd0: magic_nxt  = (gather_nxt == sbhv_pkg::STORE_MAGIC);
            3'd1: kind_nxt   = (gather_nxt == 32'd1) ? sbhv_pkg::KIND_V1 :
                               (gather_nxt == 32'd2) ? sbhv_pkg::KIND_V2 :
                                                       sbhv_pkg::KIND_UNKNOWN;
            3'd2: count_nxt  = gather_nxt;
            3'd3: length_nxt = gather_nxt;
            3'd4: csum_nxt   = gather_nxt;
            3'd5: if (kind_r == sbhv_pkg::KIND_V2) gen_nxt = gather_nxt;
            default: ;
          endcase
        end
      end
      // The version word lands well before the hashed region starts, so the
      // registered kind and length are already final here.
      if (kind_r != sbhv_pkg::KIND_UNKNOWN &&
          pos_r >= 16'(sbhv_pkg::hdr_len(kind_r)) &&
          {16'd0, pos_r} < length_r) begin
        hash_nxt = (hash_r ^ {24'd0, in_word.data_byte}) * sbhv_pkg::FNV_PRIME;
      end
      if (pos_r != sbhv_pkg::POS_MAX) begin
        pos_nxt = pos_r + 16'd1;
      end else begin
        ovr_nxt = 1'b1;
      end
    end

    if (in_acc && in_word.bank_end) begin
      snap_nxt.magic_good = magic_nxt;
      snap_nxt.kind       = kind_nxt;
      snap_nxt.count      = count_nxt;
      snap_nxt.length     = length_nxt;
      snap_nxt.checksum   = csum_nxt;
      snap_nxt.generation = gen_nxt;
      snap_nxt.hash       = hash_nxt;
      snap_nxt.received   = ovr_nxt ? sbhv_pkg::POS_OVERRUN : {1'b0, pos_nxt};

      pos_nxt    = 16'd0;
      ovr_nxt    = 1'b0;
      gather_nxt = 32'd0;
      magic_nxt  = 1'b0;
      kind_nxt   = sbhv_pkg::KIND_UNKNOWN;
      count_nxt  = 32'd0;
      length_nxt = 32'd0;
      csum_nxt   = 32'd0;
      gen_nxt    = 32'd0;
      hash_nxt   = sbhv_pkg::FNV_BASIS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 16'd0;
      ovr_r    <= 1'b0;
      gather_r <= 32'd0;
      magic_r  <= 1'b0;
      kind_r   <= sbhv_pkg::KIND_UNKNOWN;
      count_r  <= 32'd0;
      length_r <= 32'd0;
      csum_r   <= 32'd0;
      gen_r    <= 32'd0;
      hash_r   <= sbhv_pkg::FNV_BASIS;
      snap_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      ovr_r    <= ovr_nxt;
      gather_r <= gather_nxt;
      magic_r  <= magic_nxt;
      kind_r   <= kind_nxt;
      count_r  <= count_nxt;
      length_r <= length_nxt;
      csum_r   <= csum_nxt;
      gen_r    <= gen_nxt;
      hash_r   <= hash_nxt;
      if (snap_free) begin
        snap_v_r <= in_acc && in_word.bank_end;
      end
      if (out_free) begin
        out_v_r <= snap_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    snap_r <= snap_nxt;
    if (out_free) begin
      res_r <= verdict;
    end
  end

  sbhv_verdict u_verdict (
    .snap (snap_r),
    .res  (verdict)
  );

  assign out_word.valid           = out_v_r;
  assign out_word.status          = res_r.status;
  assign out_word.header_bytes    = res_r.header_bytes;
  assign out_word.dir_entries     = res_r.dir_entries;
  assign out_word.total_bytes     = res_r.total_bytes;
  assign out_word.bank_generation = res_r.bank_generation;

  // A final byte always leaves a captured bank and a fresh header state.
  a_end_captured: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_word.bank_end) |=> (snap_v_r && pos_r == 16'd0 &&
                                      hash_r == sbhv_pkg::FNV_BASIS))
    else $error("final byte did not capture the bank or clear the state");

  // With the capture stage empty the block must never stall its source.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !snap_v_r |-> in_word.ready)
    else $error("input stalled with an empty capture stage");

  // A good verdict always lies within the directory and length bounds.
  a_ok_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && res_r.status == sbhv_pkg::ST_OK) |->
      (32'(res_r.dir_entries) <= 32'(sbhv_pkg::MAX_ENTRIES) &&
       res_r.total_bytes >= 16'(res_r.header_bytes)))
    else $error("good verdict outside the size bounds");

  // The overrun flag is only ever set once the position has saturated.
  a_overrun_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    ovr_r |-> (pos_r == sbhv_pkg::POS_MAX))
    else $error("overrun flagged before the position saturated");

  // A waiting verdict moves into the output register as soon as it is free.
  a_verdict_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (snap_v_r && out_free) |=> out_v_r)
    else $error("captured bank lost on its way to the output");

endmodule

### hw/rtl/sbhv_verdict.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbhv_verdict
// Turns the captured header state of a bank into its status and result word.
// ----------------------------------------------------------------------------
module sbhv_verdict (
  input  sbhv_pkg::snap_t snap,
  output sbhv_pkg::res_t  res
);

  logic [4:0]                  hsz;
  logic [sbhv_pkg::CNT_W-1:0]  cnt_low;
  logic [sbhv_pkg::NEED_W-1:0] need;
  logic                        size_bad;
  sbhv_pkg::status_t           status;

  always_comb begin
    hsz     = sbhv_pkg::hdr_len(snap.kind);
    // Only the low bits matter: a larger count fails the count bound anyway.
    cnt_low = snap.count[sbhv_pkg::CNT_W-1:0];
    need    = sbhv_pkg::NEED_W'(hsz) +
              sbhv_pkg::NEED_W'(cnt_low) * sbhv_pkg::NEED_W'(sbhv_pkg::ENTRY_BYTES);

    size_bad = (snap.count > 32'(sbhv_pkg::MAX_ENTRIES)) ||
               (snap.length < 32'(hsz)) ||
               (snap.length > 32'(sbhv_pkg::BANK_BYTES)) ||
               (32'(need) > snap.length) ||
               (32'(snap.received) < snap.length);

    if (!snap.magic_good) begin
      status = sbhv_pkg::ST_BAD_MAGIC;
    end else if (snap.kind == sbhv_pkg::KIND_UNKNOWN) begin
      status = sbhv_pkg::ST_BAD_VERSION;
    end else if (size_bad) begin
      status = sbhv_pkg::ST_BAD_SIZES;
    end else if (snap.hash != snap.checksum) begin
      status = sbhv_pkg::ST_BAD_CHECKSUM;
    end else begin
      status = sbhv_pkg::ST_OK;
    end

    res.status          = status;
    res.header_bytes    = hsz;
    res.dir_entries     = (status == sbhv_pkg::ST_OK) ? snap.count[5:0] : 6'd0;
    res.total_bytes     = (status == sbhv_pkg::ST_OK) ? snap.length[15:0] : 16'd0;
    res.bank_generation = (snap.magic_good && snap.kind == sbhv_pkg::KIND_V2) ?
                          snap.generation : 32'd0;
  end

endmodule
